@@ rtl/core/g24c_pkg.sv @@
// Shared types, generator table and parity helpers for the extended Golay (24,12) codec.
// No dependencies; imported by the front, back and top-level modules and by the testbench.
`default_nettype none

package g24c_pkg;

	localparam int DataW = 12;
	localparam int WordW = 24;
	localparam int DistW = 5;

	localparam logic [DistW-1:0] DIST_FAIL = 5'd4;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// Queue entry: syn holds the parity bits on encode, the syndrome on decode.
	typedef struct packed {
		op_t              op;
		logic [DataW-1:0] data;
		logic [DataW-1:0] syn;
	} mid_t;

	typedef struct packed {
		logic [WordW-1:0] word_out;
		logic [DistW-1:0] distance;
		logic             failed;
	} res_t;

	// Low 12 bits of each generator row; row 0 drives parity bit 11 (word bit 23).
	localparam logic [DataW-1:0] GEN_ROWS [DataW] = '{
		12'h8ED, 12'h1DB, 12'h3B5, 12'h769,
		12'hED1, 12'hDA3, 12'hB47, 12'h68F,
		12'hD1D, 12'hA3B, 12'h477, 12'hFFE
	};

	function automatic logic [3:0] pop12(input logic [DataW-1:0] v);
		logic [2:0] n0;
		logic [2:0] n1;
		logic [2:0] n2;
		n0 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
		n1 = 3'(v[4]) + 3'(v[5]) + 3'(v[6]) + 3'(v[7]);
		n2 = 3'(v[8]) + 3'(v[9]) + 3'(v[10]) + 3'(v[11]);
		return 4'(n0) + 4'(n1) + 4'(n2);
	endfunction

	// Parity bits of a data word, in codeword order.
	function automatic logic [DataW-1:0] enc_par(input logic [DataW-1:0] d);
		logic [DataW-1:0] p;
		for (int i = 0; i < DataW; i++) begin
			p[DataW-1-i] = ^(GEN_ROWS[i] & d);
		end
		return p;
	endfunction

	// Syndrome of a single error at data bit j.
	function automatic logic [DataW-1:0] col_syn(input int j);
		logic [DataW-1:0] s;
		for (int i = 0; i < DataW; i++) begin
			s[DataW-1-i] = GEN_ROWS[i][j];
		end
		return s;
	endfunction

	// Transposed product: maps a syndrome onto the data half.
	function automatic logic [DataW-1:0] tr_mul(input logic [DataW-1:0] s);
		logic [DataW-1:0] q;
		for (int j = 0; j < DataW; j++) begin
			q[j] = ^(col_syn(j) & s);
		end
		return q;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/g24c_fifo.sv @@
// Small register-based queue used between front and back and on the result side.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module g24c_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/g24c_front.sv @@
// Front end: classifies an incoming item and forms parity or syndrome for the queue.
// Depends on g24c_pkg.
`default_nettype none

module g24c_front (
	input  logic                   opcode,
	input  logic [23:0]            word_in,
	output g24c_pkg::mid_t         item
);

	import g24c_pkg::*;

	logic [DataW-1:0] par;

	always_comb begin
		par       = enc_par(word_in[DataW-1:0]);
		item.op   = op_t'(opcode);
		item.data = word_in[DataW-1:0];
		item.syn  = (op_t'(opcode) == OP_DECODE) ? (par ^ word_in[WordW-1:DataW]) : par;
	end

endmodule

`default_nettype wire

@@ rtl/core/g24c_back.sv @@
// Back end: builds the codeword or corrects up to three errors from the syndrome.
// Depends on g24c_pkg.
`default_nettype none

module g24c_back (
	input  g24c_pkg::mid_t item,
	output g24c_pkg::res_t res
);

	import g24c_pkg::*;

	logic [DataW-1:0] q;
	logic [DataW-1:0] ed;
	logic [3:0]       ws;
	logic [3:0]       wq;
	logic [3:0]       w2 [DataW];
	logic [3:0]       w4 [DataW];
	logic [DistW-1:0] err_dist;
	logic             hit;

	// A pattern of weight three or less is unique per coset, so all hits agree.
	always_comb begin
		q        = tr_mul(item.syn);
		ws       = pop12(item.syn);
		wq       = pop12(q);
		hit      = 1'b0;
		ed       = '0;
		err_dist = '0;
		if (ws <= 4'd3) begin
			hit      = 1'b1;
			err_dist = err_dist | DistW'(ws);
		end
		if (wq <= 4'd3) begin
			hit      = 1'b1;
			ed       = ed | q;
			err_dist = err_dist | DistW'(wq);
		end
		for (int j = 0; j < DataW; j++) begin
			w2[j] = pop12(item.syn ^ col_syn(j));
			if (w2[j] <= 4'd2) begin
				hit      = 1'b1;
				ed[j]    = 1'b1;
				err_dist = err_dist | (DistW'(w2[j]) + DistW'(1));
			end
		end
		for (int i = 0; i < DataW; i++) begin
			w4[i] = pop12(q ^ GEN_ROWS[i]);
			if (w4[i] <= 4'd2) begin
				hit      = 1'b1;
				ed       = ed | (q ^ GEN_ROWS[i]);
				err_dist = err_dist | (DistW'(w4[i]) + DistW'(1));
			end
		end

		if (item.op == OP_ENCODE) begin
			res.word_out = {item.syn, item.data};
			res.distance = '0;
			res.failed   = 1'b0;
		end else if (!hit) begin
			res.word_out = '0;
			res.distance = DIST_FAIL;
			res.failed   = 1'b1;
		end else begin
			res.word_out = {{(WordW-DataW){1'b0}}, item.data ^ ed};
			res.distance = err_dist;
			res.failed   = 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/golay24_codec_unit.sv @@
// Extended Golay (24,12) codec: encodes 12 data bits into a 24-bit codeword, or decodes a
// received word by syndrome, correcting up to three bit errors and flagging four as failed.
// One item per clock is taken while full is low, one result per clock given out while pop
// is high and empty is low. Results pass both queues: the front computes parity or syndrome
// into a MID_DEPTH-entry queue, and the back corrects into an OUT_DEPTH-entry result queue.
// Either side may stall alone; full rises only when the front queue holds MID_DEPTH items.
// Depends on g24c_pkg, g24c_fifo, g24c_front and g24c_back.
`default_nettype none

module golay24_codec_unit #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [23:0] word_in,
	output logic        empty,
	input  logic        pop,
	output logic [23:0] word_out,
	output logic [4:0]  distance,
	output logic        failed
);

	import g24c_pkg::*;

	localparam int MidW = $bits(mid_t);
	localparam int ResW = $bits(res_t);

	mid_t            front_item;
	mid_t            back_item;
	res_t            back_res;
	res_t            out_res;
	logic [MidW-1:0] mid_rd;
	logic [ResW-1:0] out_rd;
	logic            mid_empty;
	logic            out_full;
	logic            back_go;

	g24c_front u_front (
		.opcode  (opcode),
		.word_in (word_in),
		.item    (front_item)
	);

	g24c_fifo #(
		.WIDTH (MidW),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (MidW'(front_item)),
		.pop     (back_go),
		.rd_data (mid_rd),
		.full    (full),
		.empty   (mid_empty)
	);

	assign back_item = mid_t'(mid_rd);
	assign back_go   = ~mid_empty & ~out_full;

	g24c_back u_back (
		.item (back_item),
		.res  (back_res)
	);

	g24c_fifo #(
		.WIDTH (ResW),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (back_go),
		.wr_data (ResW'(back_res)),
		.pop     (pop),
		.rd_data (out_rd),
		.full    (out_full),
		.empty   (empty)
	);

	assign out_res  = res_t'(out_rd);
	assign word_out = out_res.word_out;
	assign distance = out_res.distance;
	assign failed   = out_res.failed;

`ifndef SYNTHESIS
	a_fail_dist: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (failed == (distance == DIST_FAIL)))
		else $error("failed flag disagrees with distance");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && failed) |-> (word_out == '0))
		else $error("failed result carries data");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (distance <= DIST_FAIL))
		else $error("distance beyond covering radius");

	a_back_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!mid_empty && !out_full) |=> !empty)
		else $error("back transfer lost before result queue");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for golay24_codec_unit: encode and decode transfers with random idling.
// Predicts encode results from a codeword table and decode results by nearest-codeword search over all 4096 codewords.
// Depends on g24c_pkg and the golay24_codec_unit RTL.

module tb_top;
	import g24c_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 900;
	localparam int IDLE_PCT = 31;

	localparam logic [23:0] GEN_ROW [12] = '{
		24'h8008ED, 24'h4001DB, 24'h2003B5, 24'h100769,
		24'h080ED1, 24'h040DA3, 24'h020B47, 24'h01068F,
		24'h008D1D, 24'h004A3B, 24'h002477, 24'h001FFE
	};

	typedef struct {
		op_t         op;
		logic [23:0] word;
		bit          drain;
	} codec_item_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        opcode;
	logic [23:0] word_in;
	logic        empty;
	logic        pop;
	logic [23:0] word_out;
	logic [4:0]  distance;
	logic        failed;

	codec_item_t pending_words[$];
	res_t        results_due[$];
	logic [23:0] cw_table [4096];
	bit          in_taken;
	int          sent_count;
	int          err_count;
	int          cycles;
	int          stall_left;

	golay24_codec_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.opcode  (opcode),
		.word_in (word_in),
		.empty   (empty),
		.pop     (pop),
		.word_out(word_out),
		.distance(distance),
		.failed  (failed)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [23:0] codeword_of(logic [11:0] d);
		logic [11:0] par;
		for (int i = 0; i < 12; i++) begin
			par[11-i] = ^(GEN_ROW[i][11:0] & d);
		end
		return {par, d};
	endfunction

	// Brute-force nearest codeword; strict < keeps the smallest data value on ties.
	function automatic res_t golay_result(op_t op, logic [23:0] w);
		res_t        r;
		int          best_d;
		int          dd;
		logic [11:0] best_v;
		r = '0;
		if (op == OP_ENCODE) begin
			r.word_out = cw_table[w[11:0]];
		end else begin
			best_d = 25;
			best_v = '0;
			for (int v = 0; v < 4096; v++) begin
				dd = $countones(cw_table[v] ^ w);
				if (dd < best_d) begin
					best_d = dd;
					best_v = v[11:0];
				end
			end
			r.distance = best_d[4:0];
			if (best_d >= int'(DIST_FAIL)) begin
				r.failed = 1'b1;
			end else begin
				r.word_out = {12'b0, best_v};
			end
		end
		return r;
	endfunction

	function automatic logic [23:0] error_mask(int k);
		logic [23:0] m;
		m = '0;
		while ($countones(m) < k) begin
			m[$urandom_range(23, 0)] = 1'b1;
		end
		return m;
	endfunction

	function automatic bit steady_window();
		return sent_count >= 400 && sent_count < 560;
	endfunction

	task automatic queue_word(op_t op, logic [23:0] w, bit drain);
		codec_item_t it;
		it.op = op;
		it.word = w;
		it.drain = drain;
		pending_words.push_back(it);
	endtask

	// input side: record transfers and predict
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= push && !full;
			if (push && !full) begin
				results_due.push_back(golay_result(op_t'(opcode), word_in));
				sent_count <= sent_count + 1;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		codec_item_t it;
		if (arst_n && (!push || in_taken)) begin
			if (pending_words.size() != 0
				&& !(pending_words[0].drain && results_due.size() != 0)
				&& (steady_window() || $urandom_range(99, 0) >= IDLE_PCT)) begin
				it = pending_words.pop_front();
				opcode <= it.op;
				word_in <= it.word;
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random idling plus occasional long stalls to back up the queues
	always @(negedge clk) begin
		if (arst_n) begin
			if (steady_window()) begin
				stall_left <= 0;
				pop <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				pop <= 1'b0;
			end else if ($urandom_range(99, 0) < 2) begin
				stall_left <= $urandom_range(20, 5);
				pop <= 1'b0;
			end else begin
				pop <= $urandom_range(99, 0) >= IDLE_PCT;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				err_count++;
				if (err_count <= 10) begin
					$display("unexpected result: word_out=%h distance=%0d failed=%b",
						word_out, distance, failed);
				end
			end else begin
				want = results_due.pop_front();
				if (word_out !== want.word_out || distance !== want.distance
					|| failed !== want.failed) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: exp word_out=%h distance=%0d failed=%b",
							want.word_out, want.distance, want.failed);
						$display("          got word_out=%h distance=%0d failed=%b",
							word_out, distance, failed);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL golay24_codec_unit");
			$finish;
		end
	end

	initial begin
		logic [23:0] cw;
		int          roll;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		opcode = 1'b0;
		word_in = '0;
		in_taken = 1'b0;
		sent_count = 0;
		err_count = 0;
		cycles = 0;
		stall_left = 0;
		for (int v = 0; v < 4096; v++) begin
			cw_table[v] = codeword_of(v[11:0]);
		end

		// directed: field extremes, high bits on encode, exact / 1..3 errors / uncorrectable
		queue_word(OP_ENCODE, 24'h000000, 1'b0);
		queue_word(OP_ENCODE, 24'h000FFF, 1'b0);
		queue_word(OP_ENCODE, 24'hFFFFFF, 1'b0);
		queue_word(OP_ENCODE, 24'hFFF000, 1'b0);
		queue_word(OP_ENCODE, 24'h000001, 1'b0);
		queue_word(OP_ENCODE, 24'hA5A800, 1'b0);
		queue_word(OP_DECODE, 24'h000000, 1'b0);
		queue_word(OP_DECODE, 24'hFFFFFF, 1'b0);
		queue_word(OP_DECODE, cw_table[12'hFFF], 1'b0);
		queue_word(OP_DECODE, cw_table[12'h5A5], 1'b0);
		queue_word(OP_DECODE, 24'h000001, 1'b0);
		queue_word(OP_DECODE, 24'h800000, 1'b0);
		queue_word(OP_DECODE, cw_table[12'h123] ^ 24'h000810, 1'b0);
		queue_word(OP_DECODE, cw_table[12'hABC] ^ 24'h840001, 1'b0);
		queue_word(OP_DECODE, cw_table[12'h800] ^ 24'h007000, 1'b0);
		queue_word(OP_DECODE, 24'h00000F, 1'b0);
		queue_word(OP_DECODE, 24'hF00000, 1'b0);
		queue_word(OP_DECODE, cw_table[12'h3C3] ^ 24'h108101, 1'b0);
		queue_word(OP_DECODE, cw_table[12'hFFF] ^ 24'h0F0000, 1'b0);
		queue_word(OP_DECODE, 24'h0F0F0F, 1'b0);
		queue_word(OP_DECODE, 24'h555555, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(99, 0);
			if (roll < 30) begin
				queue_word(OP_ENCODE, 24'($urandom()), n == 0 || n == 450);
			end else if (roll < 82) begin
				cw = cw_table[$urandom_range(4095, 0)];
				queue_word(OP_DECODE, cw ^ error_mask($urandom_range(4, 0)),
					n == 0 || n == 450);
			end else begin
				queue_word(OP_DECODE, 24'($urandom()), n == 0 || n == 450);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || push || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS golay24_codec_unit");
		end else begin
			$display("FAIL golay24_codec_unit");
		end
		$finish;
	end

endmodule

@@ golay24_codec_unit.f @@
rtl/core/g24c_pkg.sv
rtl/core/g24c_fifo.sv
rtl/core/g24c_front.sv
rtl/core/g24c_back.sv
rtl/core/golay24_codec_unit.sv
tb/tb_top.sv
